[hw/rtl/console_argument_tokenizer_unit_defines.svh]
// Assertion macros for the argument tokenizer checker.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef CONSOLE_ARGUMENT_TOKENIZER_UNIT_DEFINES_SVH
`define CONSOLE_ARGUMENT_TOKENIZER_UNIT_DEFINES_SVH

// same-cycle implication
`define CAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/cat_pkg.sv]
// Shared types and constants of the argument tokenizer.
// Used by the front, queue, back and top level; depends on nothing.
package cat_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [7:0] MAX_ARGS_RST = 8'd16;
  localparam logic [7:0] COUNT_MAX    = 8'hFF;

  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_MISSING_QUOTE = 2'd1;
  localparam logic [1:0] ST_TOO_MANY      = 2'd2;

  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_RUN     = 3'd1,
    MODE_QUOTED  = 3'd2,
    MODE_QBSLASH = 3'd3,
    MODE_AFTER   = 3'd4
  } mode_t;

  // one queued entry: a result, optionally preceded by a copied backslash
  typedef struct packed {
    logic [7:0] data;
    logic       data_ok;
    logic       start;
    logic [7:0] num;
    logic       done;
    logic [1:0] status;
    logic       dual;
  } entry_t;

  typedef struct packed {
    logic   en;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   not_empty;
    entry_t entry;
  } qout_t;

endpackage

[hw/rtl/cat_front.sv]
// Front of the argument tokenizer: accepts bytes, tracks scan state, classifies.
// Depends on cat_pkg; pushes entries into cat_queue.
module cat_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_ch,
  input  logic             in_end_of_line,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data,
  input  logic             q_full,
  output cat_pkg::push_t   push
);

  cat_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]     cnt_r, cnt_nxt;
  logic           err_r, err_nxt;
  logic [7:0]     max_r;
  logic           acc;
  logic           is_sp;
  logic           do_between;
  logic [7:0]     cnt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cat_pkg::MODE_BETWEEN;
      cnt_r  <= 8'd0;
      err_r  <= 1'b0;
      max_r  <= cat_pkg::MAX_ARGS_RST;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      err_r  <= err_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
  end

  always_comb begin
    in_stall   = q_full;
    acc        = in_valid && !q_full;
    is_sp      = (in_ch == cat_pkg::CH_SPACE) || (in_ch == cat_pkg::CH_TAB) ||
                 (in_ch == cat_pkg::CH_CR) || (in_ch == cat_pkg::CH_LF);
    cnt_inc    = (cnt_r == cat_pkg::COUNT_MAX) ? cnt_r : cnt_r + 8'd1;
    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    err_nxt    = err_r;
    do_between = 1'b0;
    push.en            = 1'b0;
    push.entry.data    = 8'd0;
    push.entry.data_ok = 1'b0;
    push.entry.start   = 1'b0;
    push.entry.num     = cnt_r;
    push.entry.done    = 1'b0;
    push.entry.status  = cat_pkg::ST_OK;
    push.entry.dual    = 1'b0;
    if (acc) begin
      if (in_end_of_line) begin
        push.en         = 1'b1;
        push.entry.done = 1'b1;
        if (err_r) begin
          push.entry.status = cat_pkg::ST_TOO_MANY;
        end else if (mode_r == cat_pkg::MODE_QUOTED || mode_r == cat_pkg::MODE_QBSLASH) begin
          push.entry.status = cat_pkg::ST_MISSING_QUOTE;
        end
        mode_nxt = cat_pkg::MODE_BETWEEN;
        cnt_nxt  = 8'd0;
        err_nxt  = 1'b0;
      end else if (!err_r) begin
        case (mode_r)
          cat_pkg::MODE_RUN: begin
            if (is_sp) begin
              mode_nxt = cat_pkg::MODE_AFTER;
            end else begin
              push.en            = 1'b1;
              push.entry.data    = in_ch;
              push.entry.data_ok = 1'b1;
            end
          end
          cat_pkg::MODE_QUOTED: begin
            if (in_ch == cat_pkg::CH_QUOTE) begin
              mode_nxt = cat_pkg::MODE_AFTER;
            end else if (in_ch == cat_pkg::CH_BSLASH) begin
              mode_nxt = cat_pkg::MODE_QBSLASH;
            end else begin
              push.en            = 1'b1;
              push.entry.data    = in_ch;
              push.entry.data_ok = 1'b1;
            end
          end
          cat_pkg::MODE_QBSLASH: begin
            push.en            = 1'b1;
            push.entry.data    = in_ch;
            push.entry.data_ok = 1'b1;
            push.entry.dual    = (in_ch != cat_pkg::CH_BSLASH) &&
                                 (in_ch != cat_pkg::CH_QUOTE);
            mode_nxt = cat_pkg::MODE_QUOTED;
          end
          cat_pkg::MODE_AFTER: begin
            if (cnt_r >= max_r) begin
              err_nxt = 1'b1;
            end else begin
              do_between = 1'b1;
            end
          end
          default: begin
            do_between = 1'b1;
          end
        endcase
        if (do_between) begin
          if (is_sp) begin
            mode_nxt = cat_pkg::MODE_BETWEEN;
          end else begin
            cnt_nxt          = cnt_inc;
            push.en          = 1'b1;
            push.entry.num   = cnt_inc;
            push.entry.start = 1'b1;
            if (in_ch == cat_pkg::CH_QUOTE) begin
              mode_nxt = cat_pkg::MODE_QUOTED;
            end else begin
              mode_nxt           = cat_pkg::MODE_RUN;
              push.entry.data    = in_ch;
              push.entry.data_ok = 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

[hw/rtl/cat_queue.sv]
// Short entry queue between the tokenizer front and the output back end.
// Depends on cat_pkg for the entry types.
module cat_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cat_pkg::push_t push,
  output logic           full,
  input  logic           pop,
  output cat_pkg::qout_t qout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cat_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full           = (cnt_r == CNT_FULL);
  assign qout.not_empty = (cnt_r != '0);
  assign qout.entry     = mem_r[rd_ptr_r];
  assign do_push        = push.en && !full;
  assign do_pop         = pop && (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

[hw/rtl/cat_back.sv]
// Back end of the argument tokenizer: expands queued entries into results.
// Depends on cat_pkg; drains cat_queue into the output register.
module cat_back (
  input  logic           clk,
  input  logic           rst_n,
  input  cat_pkg::qout_t qout,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_out_byte,
  output logic           out_out_valid,
  output logic           out_arg_start,
  output logic [7:0]     out_arg_number,
  output logic           out_line_done,
  output logic [1:0]     out_status,
  output logic           out_last
);

  logic       vld_r, vld_nxt;
  logic       pend_r, pend_nxt;
  logic [7:0] pend_data_r;
  logic [7:0] byte_r, num_r;
  logic       ok_r, start_r, done_r, last_r;
  logic [1:0] status_r;
  logic       load;

  assign load = !vld_r || !out_stall;

  always_comb begin
    pop      = 1'b0;
    vld_nxt  = vld_r;
    pend_nxt = pend_r;
    if (load) begin
      if (pend_r) begin
        vld_nxt  = 1'b1;
        pend_nxt = 1'b0;
      end else if (qout.not_empty) begin
        pop      = 1'b1;
        vld_nxt  = 1'b1;
        pend_nxt = qout.entry.dual;
      end else begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_r) begin
        byte_r  <= pend_data_r;
        ok_r    <= 1'b1;
        start_r <= 1'b0;
        last_r  <= 1'b1;
      end else if (qout.not_empty) begin
        num_r    <= qout.entry.num;
        start_r  <= qout.entry.start;
        done_r   <= qout.entry.done;
        status_r <= qout.entry.status;
        ok_r     <= qout.entry.data_ok;
        if (qout.entry.dual) begin
          byte_r      <= cat_pkg::CH_BSLASH;
          pend_data_r <= qout.entry.data;
          last_r      <= 1'b0;
        end else begin
          byte_r <= qout.entry.data_ok ? qout.entry.data : 8'd0;
          last_r <= 1'b1;
        end
      end
    end
  end

  assign out_valid      = vld_r;
  assign out_out_byte   = byte_r;
  assign out_out_valid  = ok_r;
  assign out_arg_start  = start_r;
  assign out_arg_number = num_r;
  assign out_line_done  = done_r;
  assign out_status     = status_r;
  assign out_last       = last_r;

endmodule

[hw/rtl/console_argument_tokenizer_unit.sv]
// After its byte is accepted, a result is held in a queue entry and then in the output register.
// Throughput: one byte per cycle while the queue is not full (in_stall); a copied backslash escape
// takes two output transactions, and the QUEUE_DEPTH-entry queue absorbs that and output stalls.
// Reset: synchronous rst_n clears the scan state and queue and sets max_args to 16.
// Top level: front (cat_front) -> queue (cat_queue) -> back (cat_back).
module console_argument_tokenizer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_end_of_line,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic       out_out_valid,
  output logic       out_arg_start,
  output logic [7:0] out_arg_number,
  output logic       out_line_done,
  output logic [1:0] out_status,
  output logic       out_last
);

  cat_pkg::push_t push;
  cat_pkg::qout_t qout;
  logic           q_full;
  logic           pop;

  cat_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ch          (in_ch),
    .in_end_of_line (in_end_of_line),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .q_full         (q_full),
    .push           (push)
  );

  cat_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .qout  (qout)
  );

  cat_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .qout           (qout),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_out_byte   (out_out_byte),
    .out_out_valid  (out_out_valid),
    .out_arg_start  (out_arg_start),
    .out_arg_number (out_arg_number),
    .out_line_done  (out_line_done),
    .out_status     (out_status),
    .out_last       (out_last)
  );

endmodule

[hw/rtl/cat_checker.sv]
// Port-level checker for the argument tokenizer, bound to the top level.
// Depends on console_argument_tokenizer_unit_defines.svh for the assertion macros.
`include "console_argument_tokenizer_unit_defines.svh"

module cat_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_out_byte,
  input logic       out_out_valid,
  input logic       out_arg_start,
  input logic [7:0] out_arg_number,
  input logic       out_line_done,
  input logic [1:0] out_status,
  input logic       out_last
);

  `CAT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_out_byte) && $stable(out_last), "stalled transaction changed")
  `CAT_ASSERT_NOW(a_byte_zero, out_valid && !out_out_valid, out_out_byte == 8'd0, "byte not zero outside an argument")
  `CAT_ASSERT_NOW(a_status_done, out_valid && (out_status != cat_pkg::ST_OK), out_line_done, "status set before line end")
  `CAT_ASSERT_NOW(a_done_shape, out_valid && out_line_done, out_last && !out_arg_start && !out_out_valid, "malformed line-end transaction")
  `CAT_ASSERT_NOW(a_start_num, out_valid && out_arg_start, out_arg_number != 8'd0, "argument start with zero count")

endmodule

bind console_argument_tokenizer_unit cat_checker u_cat_checker (.*);
